// ----- design/calendar_date_counter_unit_macros.svh -----
// Assertion helpers for the calendar date counter.
`ifndef CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar_date_counter_unit: check failed");

// Next-cycle implication, checked out of reset.
`define CDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar_date_counter_unit: check failed");

`endif

// ----- design/cdc_pkg.sv -----
`timescale 1ns / 1ps

package cdc_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned SERIAL_W = 22;
  // full day count of a load, before it wraps to SERIAL_W
  localparam int unsigned DAYS_W   = SERIAL_W + 1;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 14'd1900;
  localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;

  // leaps_upto(1899)
  localparam logic [SERIAL_W-1:0] BASE_LEAPS = 22'd460;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_NEXT = 2'd1,
    FN_PREV = 2'd2,
    FN_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // Year modulo 400 to leap flag.
  function automatic logic is_leap(input logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  // Days in month; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // n / 100 by reciprocal, exact for n below 43690.
  function automatic logic [7:0] div100(input logic [13:0] n);
    logic [26:0] p;
    p = {13'd0, n} * 27'd5243;
    return p[26:19];
  endfunction

  // x mod 7 by folding octal digits (8 == 1 mod 7).
  function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) +
         6'(x[17:15]) + 6'(x[20:18]) + 6'(x[DAYS_W-1:21]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

// ----- design/calendar_date_counter_unit.sv -----
`timescale 1ns / 1ps
// Gregorian date counter starting at Monday 1 January 1900. Each input word
// (tuser selects: 0 load, 1 next day, 2 previous day, 3 no-op) yields exactly
// one output word with the resulting date, weekday (0 = Sunday), day number
// since 1900 and a status in tuser (0 ok, 1 invalid load ignored, 2 held at
// the 1900 or MAX_YEAR limit). One word is taken every cycle while the output
// side keeps up; each word passes the input register and then the date state:
// the day number of a load is worked out ahead of the input register, and the
// second stage applies the step to the date state, which doubles as the
// output register.
`include "calendar_date_counter_unit_macros.svh"

module calendar_date_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] load_month, [8:4] load_day, [22:9] load_year, [23] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] cur_month, [8:4] cur_day, [22:9] cur_year, [25:23] weekday,
  // [47:26] day_number
  output logic [47:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import cdc_pkg::*;

  // ---- load pre-computation ----
  logic [3:0]          lm;
  logic [4:0]          ld;
  logic [YEAR_W-1:0]   ly, ly_m1, yoff, ymod_full;
  logic [7:0]          q400, q100m1, q400m1;
  logic [8:0]          ld_ymod;
  logic                ld_leap, ld_ok;
  logic [4:0]          ld_dim;
  logic [11:0]         ld_leaps;
  logic [DAYS_W-1:0]   ld_serial;

  assign lm    = s_axis_tdata[3:0];
  assign ld    = s_axis_tdata[8:4];
  assign ly    = s_axis_tdata[22:9];
  assign ly_m1 = ly - 14'd1;
  assign yoff  = ly - BASE_YEAR;

  assign q400      = div100({2'b00, ly[13:2]});
  assign q100m1    = div100(ly_m1);
  assign q400m1    = div100({2'b00, ly_m1[13:2]});
  assign ymod_full = ly - ({q400[5:0], 8'd0} + {1'b0, q400[5:0], 7'd0} +
                           {4'd0, q400[5:0], 4'd0});
  assign ld_ymod   = ymod_full[8:0];
  assign ld_leap   = is_leap(ld_ymod);
  assign ld_dim    = month_len(lm, ld_leap);
  assign ld_ok     = (lm >= 4'd1) && (lm <= 4'd12) && (ly >= BASE_YEAR) &&
                     (ly <= MAX_YEAR) && (ld >= 5'd1) && (ld <= ld_dim);
  assign ld_leaps  = ly_m1[13:2] - 12'(q100m1) + 12'(q400m1);
  assign ld_serial = DAYS_W'(yoff) * DAYS_W'(365) + DAYS_W'(ld_leaps) -
                     DAYS_W'(BASE_LEAPS) + DAYS_W'(days_before(lm)) +
                     DAYS_W'(ld_leap && (lm > 4'd2)) + DAYS_W'(ld) - DAYS_W'(1);

  // ---- input register stage ----
  logic                s1_valid_q;
  func_e               s1_func_q;
  logic                s1_ok_q;
  logic [3:0]          s1_month_q;
  logic [4:0]          s1_day_q;
  logic [YEAR_W-1:0]   s1_year_q;
  logic [8:0]          s1_ymod_q;
  logic [DAYS_W-1:0]   s1_serial_q;
  logic                adv, in_acc;

  assign adv           = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= func_e'(s_axis_tuser);
      s1_ok_q     <= ld_ok;
      s1_month_q  <= lm;
      s1_day_q    <= ld;
      s1_year_q   <= ly;
      s1_ymod_q   <= ld_ymod;
      s1_serial_q <= ld_serial;
    end
  end

  // ---- date state / output register ----
  logic [3:0]          month_q, month_d;
  logic [4:0]          day_q, day_d;
  logic [YEAR_W-1:0]   year_q, year_d;
  logic [8:0]          ymod_q, ymod_d;
  logic [SERIAL_W-1:0] serial_q, serial_d;
  logic [2:0]          wday_q, wday_d;
  status_e             status_q, status_d;
  logic                out_valid_q;
  logic                leap_cur, at_end, at_start;
  logic [4:0]          dim_cur, dim_prev;

  assign leap_cur = is_leap(ymod_q);
  assign dim_cur  = month_len(month_q, leap_cur);
  assign dim_prev = (month_q == 4'd1) ? 5'd31 : month_len(month_q - 4'd1, leap_cur);
  assign at_end   = (month_q == 4'd12) && (day_q == 5'd31) && (year_q >= MAX_YEAR);
  assign at_start = (month_q == 4'd1) && (day_q == 5'd1) && (year_q <= BASE_YEAR);

  always_comb begin
    month_d  = month_q;
    day_d    = day_q;
    year_d   = year_q;
    ymod_d   = ymod_q;
    serial_d = serial_q;
    wday_d   = wday_q;
    status_d = ST_OK;
    unique case (s1_func_q)
      FN_LOAD: begin
        if (s1_ok_q) begin
          month_d  = s1_month_q;
          day_d    = s1_day_q;
          year_d   = s1_year_q;
          ymod_d   = s1_ymod_q;
          serial_d = s1_serial_q[SERIAL_W-1:0];
          wday_d   = mod7(s1_serial_q + DAYS_W'(1));
        end else begin
          status_d = ST_BAD_LOAD;
        end
      end
      FN_NEXT: begin
        if (at_end) begin
          status_d = ST_RANGE;
        end else begin
          if (day_q >= dim_cur) begin
            day_d = 5'd1;
            if (month_q == 4'd12) begin
              month_d = 4'd1;
              year_d  = year_q + 14'd1;
              ymod_d  = (ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1;
            end else begin
              month_d = month_q + 4'd1;
            end
          end else begin
            day_d = day_q + 5'd1;
          end
          serial_d = serial_q + 22'd1;
          wday_d   = (wday_q == 3'd6) ? 3'd0 : wday_q + 3'd1;
        end
      end
      FN_PREV: begin
        if (at_start) begin
          status_d = ST_RANGE;
        end else begin
          if (day_q <= 5'd1) begin
            day_d = dim_prev;
            if (month_q <= 4'd1) begin
              month_d = 4'd12;
              year_d  = year_q - 14'd1;
              ymod_d  = (ymod_q == 9'd0) ? 9'd399 : ymod_q - 9'd1;
            end else begin
              month_d = month_q - 4'd1;
            end
          end else begin
            day_d = day_q - 5'd1;
          end
          serial_d = serial_q - 22'd1;
          wday_d   = (wday_q == 3'd0) ? 3'd6 : wday_q - 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      year_q      <= BASE_YEAR;
      ymod_q      <= 9'd300;
      serial_q    <= '0;
      wday_q      <= 3'd1;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        month_q  <= month_d;
        day_q    <= day_d;
        year_q   <= year_d;
        ymod_q   <= ymod_d;
        serial_q <= serial_d;
        wday_q   <= wday_d;
        status_q <= status_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {serial_q, wday_q, year_q, day_q, month_q};
  assign m_axis_tuser  = status_q;

  // ---- checks ----
  `CDC_ASSERT_NOW(a_date_legal, 1'b1, (month_q != 4'd0) && (month_q <= 4'd12) && (day_q != 5'd0) && (wday_q != 3'd7))
  `CDC_ASSERT_NEXT(a_state_holds, !adv, $stable(serial_q) && $stable(year_q) && $stable(day_q))
  `CDC_ASSERT_NEXT(a_next_counts, adv && (s1_func_q == FN_NEXT) && !at_end, serial_q == $past(serial_q) + 22'd1)
  `CDC_ASSERT_NOW(a_day_fits, 1'b1, day_q <= dim_cur)

endmodule
